>>> rtl/fmhd_pkg.sv
// Package for the four-motor H-bridge drive with reversal dead time.
// Holds payload structs, per-motor state record, codes and pin maps.
// No dependencies.
package fmhd_pkg;

    localparam logic [1:0] ACT_SET      = 2'd0;
    localparam logic [1:0] ACT_DEADLINE = 2'd1;
    localparam logic [1:0] ACT_SERVICE  = 2'd2;
    localparam logic [1:0] ACT_STOP     = 2'd3;

    localparam logic [2:0] CFG_MAX_SPEED = 3'd0;
    localparam logic [2:0] CFG_CAL0      = 3'd1;
    localparam logic [2:0] CFG_CAL3      = 3'd4;
    localparam logic [2:0] CFG_DELAY     = 3'd5;

    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    localparam logic [14:0] MAX_SPEED_RST = 15'd1000;
    localparam logic [16:0] CAL_RST       = 17'h0FF00;
    localparam logic [7:0]  DELAY_RST     = 8'd20;

    localparam int DIVIDEND_W = 23;
    localparam int QUOT_W     = 8;

    typedef struct packed {
        logic [1:0]         action;
        logic [31:0]        now_ms;
        logic               armed;
        logic signed [15:0] front_left_speed;
        logic signed [15:0] front_right_speed;
        logic signed [15:0] rear_left_speed;
        logic signed [15:0] rear_right_speed;
    } t_in;

    typedef struct packed {
        logic [7:0] latch_byte;
        logic [7:0] pwm_motor0;
        logic [7:0] pwm_motor1;
        logic [7:0] pwm_motor2;
        logic [7:0] pwm_motor3;
        logic [3:0] reversing_flags;
    } t_out;

    // per-motor state kept in RAM
    typedef struct packed {
        logic [1:0]         dir;
        logic               waiting;
        logic signed [15:0] pending;
        logic [31:0]        ready;
    } t_mrec;

    function automatic logic [2:0] bit_a(input logic [1:0] m);
        case (m)
            2'd0:    bit_a = 3'd1;
            2'd1:    bit_a = 3'd2;
            2'd2:    bit_a = 3'd5;
            default: bit_a = 3'd0;
        endcase
    endfunction

    function automatic logic [2:0] bit_b(input logic [1:0] m);
        case (m)
            2'd0:    bit_b = 3'd4;
            2'd1:    bit_b = 3'd3;
            2'd2:    bit_b = 3'd7;
            default: bit_b = 3'd6;
        endcase
    endfunction

endpackage

>>> rtl/fmhd_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module fmhd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                          i_wdata,
    output logic [WIDTH-1:0]                          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/fmhd_div.sv
// Restoring divider, one quotient bit per cycle, for PWM scaling.
// Quotient is known to fit in QUOT_W bits. Depends on fmhd_pkg.
module fmhd_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [fmhd_pkg::DIVIDEND_W-1:0]     i_dividend,
    input  logic [14:0]                         i_divisor,
    output logic                                o_done,
    output logic [fmhd_pkg::QUOT_W-1:0]         o_quot
);
    logic [fmhd_pkg::DIVIDEND_W-1:0] r_rem;
    logic [fmhd_pkg::QUOT_W-1:0]     r_quot;
    logic [2:0]                      r_k;
    logic                            r_busy;
    logic                            r_done;
    logic [fmhd_pkg::DIVIDEND_W-1:0] dsh;

    assign dsh = fmhd_pkg::DIVIDEND_W'(i_divisor) << r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_k == 3'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_rem  <= i_dividend;
            r_quot <= '0;
            r_k    <= 3'd7;
        end else if (r_busy) begin
            if (r_rem >= dsh) begin
                r_rem       <= r_rem - dsh;
                r_quot[r_k] <= 1'b1;
            end
            r_k <= r_k - 3'd1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

>>> rtl/four_motor_hbridge_drive_dead_time.sv
// Four-motor H-bridge drive with reversal dead time: top level.
// Depends on fmhd_pkg, fmhd_ram and fmhd_div.
//
// One result per input transfer. Deadline and service walk the motors in
// order through the per-motor state RAM: a read state and a decision state
// per motor, plus the 8-step PWM scaling divider when the motor runs at
// nonzero speed. The next item is taken while a result still waits.
// State comes up cleared at reset through per-entry valid bits.
module four_motor_hbridge_drive_dead_time #(
    parameter int NUM_MOTORS = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  fmhd_pkg::t_in    i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output fmhd_pkg::t_out   o_out_data,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [16:0]      i_cfg_data
);
    localparam int IW = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
    localparam int RW = $bits(fmhd_pkg::t_mrec);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TW   = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_EV   = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    localparam logic [1:0] K_SKIP  = 2'd0;
    localparam logic [1:0] K_COAST = 2'd1;
    localparam logic [1:0] K_HOLD  = 2'd2;
    localparam logic [1:0] K_RUN   = 2'd3;

    logic [14:0] r_max;
    logic [16:0] r_cal [4];
    logic [7:0]  r_delay;

    logic [2:0]          r_state;
    logic [IW-1:0]       r_idx;
    fmhd_pkg::t_in       r_in;
    logic [NUM_MOTORS-1:0] r_mvalid;
    logic [NUM_MOTORS-1:0] r_tvalid;
    logic [7:0]          r_pwm [4];
    logic [7:0]          r_latch;
    logic [3:0]          r_flags;
    fmhd_pkg::t_mrec     r_rec;
    logic [14:0]         r_mag;
    logic                r_fwd;
    logic                r_out_valid;
    fmhd_pkg::t_out      r_out;

    logic [1:0]          mi;
    logic [16:0]         cal;
    logic [7:0]          lo, hi, absdiff;
    logic                neg;
    logic [RW-1:0]       m_rdata;
    logic [15:0]         t_rdata;
    fmhd_pkg::t_mrec     st, n_rec, wrec;
    logic signed [15:0]  tg, speed, sel_speed;
    logic [1:0]          req, kind;
    logic [15:0]         absv;
    logic [14:0]         n_mag;
    logic [31:0]         elapsed;
    logic                m_we, t_we, last;
    logic                div_start, div_done;
    logic [fmhd_pkg::QUOT_W-1:0] quot;
    logic [7:0]          qs;

    assign mi      = 2'(r_idx);
    assign cal     = r_cal[mi];
    assign lo      = cal[7:0];
    assign hi      = cal[15:8];
    assign neg     = hi < lo;
    assign absdiff = neg ? (lo - hi) : (hi - lo);
    assign last    = (r_idx == IW'(NUM_MOTORS - 1));

    always_comb begin
        case (mi)
            2'd0:    sel_speed = r_in.front_left_speed;
            2'd1:    sel_speed = r_in.front_right_speed;
            2'd2:    sel_speed = r_in.rear_left_speed;
            default: sel_speed = r_in.rear_right_speed;
        endcase
    end

    // decision for one motor, from the state just read
    always_comb begin
        st    = r_mvalid[r_idx] ? fmhd_pkg::t_mrec'(m_rdata) : '0;
        tg    = r_tvalid[r_idx] ? $signed(t_rdata) : 16'sd0;
        speed = (r_in.action == fmhd_pkg::ACT_DEADLINE) ? (r_in.armed ? tg : 16'sd0)
                                                        : st.pending;
        if (speed > 16'sd0)      req = fmhd_pkg::DIR_FWD;
        else if (speed < 16'sd0) req = fmhd_pkg::DIR_REV;
        else                     req = fmhd_pkg::DIR_STOP;
        absv    = speed[15] ? 16'(-speed) : speed;
        n_mag   = (absv > {1'b0, r_max}) ? r_max : absv[14:0];
        elapsed = r_in.now_ms - st.ready;
        n_rec   = st;
        kind    = K_SKIP;
        if (r_in.action == fmhd_pkg::ACT_SERVICE && !st.waiting) begin
            kind = K_SKIP;
        end else if (!st.waiting && st.dir != fmhd_pkg::DIR_STOP &&
                     req != fmhd_pkg::DIR_STOP && req != st.dir) begin
            n_rec.dir     = fmhd_pkg::DIR_STOP;
            n_rec.waiting = 1'b1;
            n_rec.pending = speed;
            n_rec.ready   = r_in.now_ms + 32'(r_delay);
            kind          = K_COAST;
        end else begin
            if (st.waiting) begin
                n_rec.pending = speed;
            end
            if (st.waiting && elapsed[31]) begin
                kind = K_HOLD;
            end else begin
                n_rec.waiting = 1'b0;
                if (n_mag == 15'd0) begin
                    n_rec.dir = fmhd_pkg::DIR_STOP;
                    kind      = K_COAST;
                end else begin
                    n_rec.dir = (speed > 16'sd0) ? fmhd_pkg::DIR_FWD : fmhd_pkg::DIR_REV;
                    kind      = K_RUN;
                end
            end
        end
    end

    assign div_start = (r_state == S_MUL);
    assign qs        = neg ? 8'(-quot) : quot;
    assign m_we      = (r_state == S_EV && (kind == K_COAST || kind == K_HOLD)) ||
                       (r_state == S_DIV && div_done);
    assign wrec      = (r_state == S_DIV) ? r_rec : n_rec;
    assign t_we      = (r_state == S_TW);

    fmhd_ram #(.WIDTH(RW), .DEPTH(NUM_MOTORS)) u_mram (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_addr  (r_idx),
        .i_wdata (wrec),
        .o_rdata (m_rdata)
    );

    fmhd_ram #(.WIDTH(16), .DEPTH(NUM_MOTORS)) u_tram (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_addr  (r_idx),
        .i_wdata (sel_speed),
        .o_rdata (t_rdata)
    );

    fmhd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (fmhd_pkg::DIVIDEND_W'(r_mag) * fmhd_pkg::DIVIDEND_W'(absdiff)),
        .i_divisor  (r_max),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max       <= fmhd_pkg::MAX_SPEED_RST;
            for (int i = 0; i < 4; i++) begin
                r_cal[i] <= fmhd_pkg::CAL_RST;
                r_pwm[i] <= 8'd0;
            end
            r_delay     <= fmhd_pkg::DELAY_RST;
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_mvalid    <= '0;
            r_tvalid    <= '0;
            r_latch     <= 8'd0;
            r_flags     <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == fmhd_pkg::CFG_MAX_SPEED) begin
                    r_max <= i_cfg_data[14:0];
                end else if (i_cfg_idx inside {[fmhd_pkg::CFG_CAL0:fmhd_pkg::CFG_CAL3]}) begin
                    r_cal[2'(i_cfg_idx - fmhd_pkg::CFG_CAL0)] <= i_cfg_data;
                end else if (i_cfg_idx == fmhd_pkg::CFG_DELAY) begin
                    r_delay <= i_cfg_data[7:0];
                end
            end
            // in S_OUT the output register is refilled below
            if (o_out_valid && i_out_ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_idx <= '0;
                        case (i_in_data.action)
                            fmhd_pkg::ACT_SET:  r_state <= S_TW;
                            fmhd_pkg::ACT_STOP: begin
                                r_mvalid <= '0;
                                r_tvalid <= '0;
                                r_latch  <= 8'd0;
                                r_flags  <= 4'd0;
                                for (int i = 0; i < 4; i++) r_pwm[i] <= 8'd0;
                                r_state  <= S_OUT;
                            end
                            default: r_state <= S_RD;
                        endcase
                    end
                end
                S_TW: begin
                    r_tvalid[r_idx] <= 1'b1;
                    if (last) r_state <= S_OUT;
                    else      r_idx   <= r_idx + IW'(1);
                end
                S_RD: r_state <= S_EV;
                S_EV: begin
                    if (kind == K_RUN) begin
                        r_rec   <= n_rec;
                        r_mag   <= n_mag;
                        r_fwd   <= (speed > 16'sd0) ^ cal[16];
                        r_state <= S_MUL;
                    end else begin
                        if (kind == K_COAST) begin
                            r_pwm[mi] <= 8'd0;
                            r_latch[fmhd_pkg::bit_a(mi)] <= 1'b0;
                            r_latch[fmhd_pkg::bit_b(mi)] <= 1'b0;
                        end
                        if (kind != K_SKIP) begin
                            r_mvalid[r_idx] <= 1'b1;
                            r_flags[mi]     <= n_rec.waiting;
                        end
                        if (last) r_state <= S_OUT;
                        else begin
                            r_idx   <= r_idx + IW'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                S_MUL: r_state <= S_DIV;
                S_DIV: begin
                    if (div_done) begin
                        r_pwm[mi] <= lo + qs;
                        r_latch[fmhd_pkg::bit_a(mi)] <= r_fwd;
                        r_latch[fmhd_pkg::bit_b(mi)] <= !r_fwd;
                        r_mvalid[r_idx] <= 1'b1;
                        r_flags[mi]     <= r_rec.waiting;
                        if (last) r_state <= S_OUT;
                        else begin
                            r_idx   <= r_idx + IW'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
        if (r_state == S_IDLE && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (r_state == S_OUT && (!r_out_valid || i_out_ready)) begin
            r_out.latch_byte      <= r_latch;
            r_out.pwm_motor0      <= r_pwm[0];
            r_out.pwm_motor1      <= r_pwm[1];
            r_out.pwm_motor2      <= r_pwm[2];
            r_out.pwm_motor3      <= r_pwm[3];
            r_out.reversing_flags <= r_flags;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

>>> test/four_motor_hbridge_drive_dead_time_tb.sv
// Testbench for the four-motor H-bridge drive with reversal dead time.
// Depends on fmhd_pkg and four_motor_hbridge_drive_dead_time; self-checking
// against a behavioral predictor, random stimulus and random backpressure.
module four_motor_hbridge_drive_dead_time_tb;
    import fmhd_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 80;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out        o_out_data;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [16:0] i_cfg_data;

    four_motor_hbridge_drive_dead_time #(.NUM_MOTORS(4)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    // predictor state
    logic [14:0]        pr_max_speed;
    logic [16:0]        pr_cal [4];
    logic [7:0]         pr_delay;
    logic signed [15:0] pr_target [4];
    logic [1:0]         pr_dir [4];
    logic               pr_wait [4];
    logic signed [15:0] pr_pending [4];
    logic [31:0]        pr_ready [4];
    logic [7:0]         pr_pwm [4];
    logic [7:0]         pr_latch;

    t_in  cmd_queue [$];
    t_out drive_expected [$];
    int   fail_count;
    int   n_accepted;
    int   n_results;
    int   n_reversals;
    int   idle_cycles;

    function automatic logic [2:0] pin_a(input int m);
        case (m)
            0: return 3'd1;
            1: return 3'd2;
            2: return 3'd5;
            default: return 3'd0;
        endcase
    endfunction

    function automatic logic [2:0] pin_b(input int m);
        case (m)
            0: return 3'd4;
            1: return 3'd3;
            2: return 3'd7;
            default: return 3'd6;
        endcase
    endfunction

    function automatic void set_pins(input int m, input logic a, input logic b);
        pr_latch[pin_a(m)] = a;
        pr_latch[pin_b(m)] = b;
    endfunction

    function automatic void drive_motor(input int m, input logic signed [15:0] speed);
        int lo, hi, mag, num, q;
        logic fwd;
        lo  = pr_cal[m][7:0];
        hi  = pr_cal[m][15:8];
        mag = speed < 0 ? -int'(speed) : int'(speed);
        if (mag > int'(pr_max_speed)) mag = pr_max_speed;
        if (mag == 0) begin
            pr_pwm[m] = 8'd0;
            set_pins(m, 1'b0, 1'b0);
            pr_dir[m] = DIR_STOP;
            return;
        end
        num = mag * (hi - lo);
        q = num < 0 ? -((-num) / int'(pr_max_speed)) : num / int'(pr_max_speed);
        fwd = speed > 0;
        if (pr_cal[m][16]) fwd = !fwd;
        set_pins(m, fwd, !fwd);
        pr_pwm[m] = 8'(lo + q);
        pr_dir[m] = speed > 0 ? DIR_FWD : DIR_REV;
    endfunction

    function automatic void serve_motor(input int m, input logic signed [15:0] speed,
                                        input logic [31:0] now);
        logic [1:0]  want;
        logic [31:0] diff;
        want = speed > 0 ? DIR_FWD : (speed < 0 ? DIR_REV : DIR_STOP);
        if (!pr_wait[m] && pr_dir[m] != DIR_STOP && want != DIR_STOP
            && want != pr_dir[m]) begin
            drive_motor(m, 16'sd0);
            pr_wait[m]    = 1'b1;
            pr_pending[m] = speed;
            pr_ready[m]   = now + 32'(pr_delay);
            n_reversals++;
            return;
        end
        if (pr_wait[m]) begin
            pr_pending[m] = speed;
            diff = now - pr_ready[m];
            if (diff[31]) return;
            pr_wait[m] = 1'b0;
        end
        drive_motor(m, speed);
    endfunction

    function automatic t_out drive_predict(input t_in c);
        t_out r;
        case (c.action)
            ACT_SET: begin
                pr_target[0] = c.front_left_speed;
                pr_target[1] = c.front_right_speed;
                pr_target[2] = c.rear_left_speed;
                pr_target[3] = c.rear_right_speed;
            end
            ACT_DEADLINE:
                for (int m = 0; m < 4; m++)
                    serve_motor(m, c.armed ? pr_target[m] : 16'sd0, c.now_ms);
            ACT_SERVICE:
                for (int m = 0; m < 4; m++)
                    if (pr_wait[m]) serve_motor(m, pr_pending[m], c.now_ms);
            default:
                for (int m = 0; m < 4; m++) begin
                    pr_target[m] = 0; pr_pwm[m] = 0; set_pins(m, 1'b0, 1'b0);
                    pr_dir[m] = DIR_STOP; pr_wait[m] = 0; pr_pending[m] = 0;
                    pr_ready[m] = 0;
                end
        endcase
        r.latch_byte = pr_latch;
        r.pwm_motor0 = pr_pwm[0];
        r.pwm_motor1 = pr_pwm[1];
        r.pwm_motor2 = pr_pwm[2];
        r.pwm_motor3 = pr_pwm[3];
        r.reversing_flags = {pr_wait[3], pr_wait[2], pr_wait[1], pr_wait[0]};
        return r;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // driver
    int in_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap <= 0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid) begin
                drive_expected.push_back(drive_predict(i_in_data));
                n_accepted++;
            end
            if (in_gap > 0 || cmd_queue.size() == 0) begin
                i_in_valid <= 1'b0;
                if (in_gap > 0) in_gap <= in_gap - 1;
            end else begin
                i_in_valid <= 1'b1;
                i_in_data  <= cmd_queue.pop_front();
                in_gap <= gap_len();
            end
        end
    end

    // monitor
    int out_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_gap <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                n_results++;
                if (drive_expected.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, o_out_data);
                    fail_count++;
                end else begin
                    t_out e;
                    e = drive_expected.pop_front();
                    if (e.latch_byte !== o_out_data.latch_byte)
                        $display("%0t: latch_byte exp %h got %h", $time,
                                 e.latch_byte, o_out_data.latch_byte);
                    if (e.pwm_motor0 !== o_out_data.pwm_motor0)
                        $display("%0t: pwm_motor0 exp %0d got %0d", $time,
                                 e.pwm_motor0, o_out_data.pwm_motor0);
                    if (e.pwm_motor1 !== o_out_data.pwm_motor1)
                        $display("%0t: pwm_motor1 exp %0d got %0d", $time,
                                 e.pwm_motor1, o_out_data.pwm_motor1);
                    if (e.pwm_motor2 !== o_out_data.pwm_motor2)
                        $display("%0t: pwm_motor2 exp %0d got %0d", $time,
                                 e.pwm_motor2, o_out_data.pwm_motor2);
                    if (e.pwm_motor3 !== o_out_data.pwm_motor3)
                        $display("%0t: pwm_motor3 exp %0d got %0d", $time,
                                 e.pwm_motor3, o_out_data.pwm_motor3);
                    if (e.reversing_flags !== o_out_data.reversing_flags)
                        $display("%0t: reversing_flags exp %b got %b", $time,
                                 e.reversing_flags, o_out_data.reversing_flags);
                    if (e !== o_out_data) fail_count++;
                end
            end
            if (out_gap > 0) begin
                i_out_ready <= 1'b0;
                out_gap <= out_gap - 1;
            end else begin
                i_out_ready <= 1'b1;
                out_gap <= gap_len();
            end
        end
    end

    // watchdog: cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (cmd_queue.size() == 0 && drive_expected.size() == 0 && !i_in_valid))
            idle_cycles <= 0;
        else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired", $time);
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic t_in make_cmd(input logic [1:0] act, input logic [31:0] now,
                                     input logic arm, input logic signed [15:0] s0,
                                     input logic signed [15:0] s1,
                                     input logic signed [15:0] s2,
                                     input logic signed [15:0] s3);
        t_in c;
        c.action = act; c.now_ms = now; c.armed = arm;
        c.front_left_speed = s0; c.front_right_speed = s1;
        c.rear_left_speed = s2; c.rear_right_speed = s3;
        return c;
    endfunction

    function automatic logic signed [15:0] rand_speed();
        int p;
        p = $urandom_range(9);
        if (p == 0) return 16'sh8000;
        if (p == 1) return 16'sh7FFF;
        if (p == 2) return 16'sd0;
        if (p < 7) return 16'($signed($urandom_range(2400)) - 1200);
        return 16'($urandom);
    endfunction

    function automatic t_in rand_cmd(inout logic [31:0] clock_ms);
        t_in c;
        int p;
        p = $urandom_range(99);
        clock_ms = clock_ms + 32'($urandom_range(15));
        c = make_cmd(ACT_DEADLINE, clock_ms, $urandom_range(9) != 0, rand_speed(),
                     rand_speed(), rand_speed(), rand_speed());
        if (p < 30) c.action = ACT_SET;
        else if (p < 65) c.action = ACT_DEADLINE;
        else if (p < 96) c.action = ACT_SERVICE;
        else c.action = ACT_STOP;
        if ($urandom_range(49) == 0) c.now_ms = $urandom;
        return c;
    endfunction

    task automatic cfg_write(input logic [2:0] idx, input logic [16:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MAX_SPEED: pr_max_speed = val[14:0];
            CFG_DELAY:     pr_delay = val[7:0];
            default: if (idx >= CFG_CAL0 && idx <= CFG_CAL3) pr_cal[idx - 1] = val;
        endcase
    endtask

    task automatic drain();
        wait (cmd_queue.size() == 0 && !i_in_valid && drive_expected.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    logic [31:0] clock_ms;
    initial begin
        fail_count = 0; n_accepted = 0; n_results = 0; n_reversals = 0;
        idle_cycles = 0;
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_out_ready = 1'b0;
        i_in_data = '0; i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        pr_max_speed = MAX_SPEED_RST; pr_delay = DELAY_RST; pr_latch = '0;
        for (int m = 0; m < 4; m++) begin
            pr_cal[m] = CAL_RST; pr_target[m] = 0; pr_dir[m] = DIR_STOP;
            pr_wait[m] = 0; pr_pending[m] = 0; pr_ready[m] = 0; pr_pwm[m] = 0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset config, extremes, reversal with wrap, stop
        clock_ms = 32'hFFFF_FFF0;
        cmd_queue.push_back(make_cmd(ACT_SERVICE, 0, 0, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(ACT_SET, 0, 0, 16'sh7FFF, 16'sh8000, 500, -1));
        cmd_queue.push_back(make_cmd(ACT_DEADLINE, clock_ms, 1, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(ACT_SET, 0, 1, -16'sd300, 16'sd700, -500, 1));
        cmd_queue.push_back(make_cmd(ACT_DEADLINE, clock_ms + 1, 1, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(ACT_SET, 0, 0, 16'sd50, 16'sd700, 500, -1));
        cmd_queue.push_back(make_cmd(ACT_DEADLINE, clock_ms + 5, 1, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(ACT_SERVICE, clock_ms + 20, 0, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(ACT_SERVICE, clock_ms + 21, 0, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(ACT_DEADLINE, 32'h10, 0, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(ACT_SET, 32'hFFFF_FFFF, 1, 16'sh8000,
                                     16'sh8000, 16'sh8000, 16'sh8000));
        cmd_queue.push_back(make_cmd(ACT_DEADLINE, 32'h20, 1, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(ACT_STOP, 32'hFFFF_FFFF, 1, 16'hFFFF,
                                     16'hFFFF, 16'hFFFF, 16'hFFFF));
        drain();

        // settings, extremes included; unknown index is ignored
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    cfg_write(CFG_MAX_SPEED, 17'd0);
                    cfg_write(CFG_DELAY, 17'd0);
                end
                1: begin
                    cfg_write(CFG_MAX_SPEED, 17'h7FFF);
                    for (int m = 0; m < 4; m++) cfg_write(CFG_CAL0 + 3'(m), 17'h1FFFF);
                    cfg_write(CFG_DELAY, 17'd255);
                end
                2: begin
                    cfg_write(CFG_MAX_SPEED, 17'd1);
                    for (int m = 0; m < 4; m++) cfg_write(CFG_CAL0 + 3'(m), 17'h000FF);
                    cfg_write(3'd6, 17'h1FFFF);
                    cfg_write(3'd7, 17'h00000);
                end
                default: begin
                    cfg_write(CFG_MAX_SPEED, 17'($urandom_range(2000, 1)));
                    for (int m = 0; m < 4; m++)
                        cfg_write(CFG_CAL0 + 3'(m), 17'($urandom));
                    cfg_write(CFG_DELAY, 17'($urandom_range(40)));
                end
            endcase
            for (int k = 0; k < 210; k++) cmd_queue.push_back(rand_cmd(clock_ms));
            drain();
        end

        $display("%0d commands, %0d results checked, %0d reversals started",
                 n_accepted, n_results, n_reversals);
        if (fail_count == 0 && drive_expected.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
